FILE: hdl/itar_pkg.sv
// Shared types, constants and a helper function for the integer-to-ASCII formatter.
package itar_pkg;

    localparam int DATA_W        = 32;
    localparam int BASE_W        = 6;
    localparam int MINW_W        = 6;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 6;
    localparam int DIGIT_SLOTS   = 32;
    localparam int ND_W          = $clog2(DIGIT_SLOTS + 1);
    localparam int MAX_WIDTH_DEF = 32;

    localparam logic [BASE_W-1:0] RADIX_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] RADIX_MAX = BASE_W'(36);
    localparam logic [BASE_W-1:0] RADIX_DEC = BASE_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h41 - 8'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DIV_WAIT,
        S_SIGN,
        S_PAD,
        S_DIGIT
    } itar_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } itar_stack_cmd_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d > DIGIT_W'(9))
        begin
            return d_ext + CHAR_ALPHA;
        end
        return d_ext + CHAR_ZERO;
    endfunction

endpackage

FILE: hdl/integer_to_ascii_radix_core.sv
// Top level of the integer-to-ASCII formatter: sequencer, output register and units.
//
// The block takes one number per transfer on the input channel (value, base,
// signed_decimal, min_width) and returns its text as a stream of ASCII
// transfers on the output channel, most significant character first, with
// last set on the final character. No terminator is sent.
// Digits are produced least significant first by one shared shift/subtract
// divider, which needs 32 steps per digit.
// in_ready is high only while the block is idle, so one number is worked on
// at a time; the next number may be taken while the last character of the
// previous one still sits in the output register.
// When the receiver holds out_ready low, the output register keeps its
// character and the sequencer waits; nothing is dropped.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and empties
// the output register; no clearing pass is needed.
module integer_to_ascii_radix_core
    import itar_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [DATA_W-1:0]   value,
    input  logic [BASE_W-1:0]   base,
    input  logic                signed_decimal,
    input  logic [MINW_W-1:0]   min_width,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   character,
    output logic                last
);

    localparam int PAD_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (PAD_W > ND_W) ? PAD_W : ND_W;

    itar_state_t state_reg, state_next;

    // Working registers for the number in progress.
    logic [DATA_W-1:0] mag_reg, mag_next;
    logic [BASE_W-1:0] radix_reg, radix_next;
    logic              sdec_reg, sdec_next;
    logic              neg_reg, neg_next;
    logic [PAD_W-1:0]  width_reg, width_next;
    logic [ND_W-1:0]   nd_reg, nd_next;
    logic [PAD_W-1:0]  pad_reg, pad_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    // Sequencer outputs.
    logic              accept;
    logic              div_start;
    logic              load_out;
    logic [CHAR_W-1:0] load_char;
    logic              load_last;
    itar_stack_cmd_t   stack_cmd;

    logic              out_free;
    logic              div_busy;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;
    logic [BASE_W-1:0] div_remainder;
    logic [DIGIT_W-1:0] top_digit;

    logic [ND_W-1:0]   nd_inc;
    logic [CMP_W-1:0]  width_ext;
    logic [CMP_W-1:0]  nd_ext;
    logic [PAD_W-1:0]  pad_calc;
    logic              quo_zero;

    itar_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (radix_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    itar_digit_stack #(
        .DEPTH (DIGIT_SLOTS)
    ) u_stack (
        .clk        (clk),
        .cmd        (stack_cmd),
        .push_digit (DIGIT_W'(div_remainder)),
        .top_digit  (top_digit)
    );

    // The output register can take a new character when it is empty or
    // its current character is transferred in this cycle.
    assign out_free = !out_valid_reg || out_ready;

    // Number of padding zeros once the digit just finished is counted.
    assign nd_inc    = nd_reg + 1'b1;
    assign width_ext = CMP_W'(width_reg);
    assign nd_ext    = CMP_W'(nd_inc);
    assign pad_calc  = (width_ext > nd_ext) ? PAD_W'(width_ext - nd_ext) : '0;
    assign quo_zero  = (div_quotient == '0);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (!quo_zero)
                    begin
                        state_next = S_DIV;
                    end
                    else if (sdec_reg)
                    begin
                        state_next = S_SIGN;
                    end
                    else if (pad_calc != '0)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_DIGIT;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    state_next = (pad_reg != '0) ? S_PAD : S_DIGIT;
                end
            end
            S_PAD:
            begin
                if (out_free && pad_reg == PAD_W'(1))
                begin
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (out_free && nd_reg == ND_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready       = 1'b0;
        accept         = 1'b0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        load_char      = CHAR_ZERO;
        load_last      = 1'b0;
        stack_cmd.push = 1'b0;
        stack_cmd.pop  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                accept   = in_valid;
            end
            S_DIV:
            begin
                div_start = 1'b1;
            end
            S_DIV_WAIT:
            begin
                stack_cmd.push = div_done;
            end
            S_SIGN:
            begin
                load_out  = out_free;
                load_char = neg_reg ? CHAR_MINUS : CHAR_PLUS;
            end
            S_PAD:
            begin
                load_out  = out_free;
                load_char = CHAR_ZERO;
            end
            S_DIGIT:
            begin
                load_out      = out_free;
                load_char     = digit_to_char(top_digit);
                load_last     = (nd_reg == ND_W'(1));
                stack_cmd.pop = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        mag_next   = mag_reg;
        radix_next = radix_reg;
        sdec_next  = sdec_reg;
        neg_next   = neg_reg;
        width_next = width_reg;
        nd_next    = nd_reg;
        pad_next   = pad_reg;

        if (accept)
        begin
            sdec_next = signed_decimal;
            nd_next   = '0;
            if (int'(min_width) > MAX_WIDTH)
            begin
                width_next = PAD_W'(MAX_WIDTH);
            end
            else
            begin
                width_next = PAD_W'(min_width);
            end
            if (signed_decimal)
            begin
                radix_next = RADIX_DEC;
                neg_next   = value[DATA_W-1];
                mag_next   = value[DATA_W-1] ? (~value + 1'b1) : value;
            end
            else
            begin
                neg_next = 1'b0;
                mag_next = value;
                if (base < RADIX_MIN)
                begin
                    radix_next = RADIX_MIN;
                end
                else if (base > RADIX_MAX)
                begin
                    radix_next = RADIX_MAX;
                end
                else
                begin
                    radix_next = base;
                end
            end
        end

        if (stack_cmd.push)
        begin
            mag_next = div_quotient;
            nd_next  = nd_inc;
            pad_next = pad_calc;
        end

        if (load_out && state_reg == S_PAD)
        begin
            pad_next = pad_reg - 1'b1;
        end

        if (stack_cmd.pop)
        begin
            nd_next = nd_reg - 1'b1;
        end
    end

    // Output register: a new character replaces a transferred one.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            char_next      = load_char;
            last_next      = load_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            nd_reg        <= '0;
            pad_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            nd_reg        <= nd_next;
            pad_reg       <= pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        radix_reg <= radix_next;
        sdec_reg  <= sdec_next;
        neg_reg   <= neg_next;
        width_reg <= width_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

`ifndef SYNTH
    // A digit is only popped while the stack still holds digits.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT) |-> (nd_reg != '0))
        else $error("digit output with empty digit stack");

    // A new number is never taken while the divider is still working.
    a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !div_busy)
        else $error("input transfer while divider busy");

    // Divider results arrive only while the sequencer waits for them.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider result outside wait state");

    // Loading the final character returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && load_last) |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after final character");
`endif

endmodule

FILE: hdl/itar_divider.sv
// Iterative restoring divider: one quotient bit per cycle, shared by every digit.
module itar_divider
    import itar_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DATA_W-1:0]   dividend,
    input  logic [BASE_W-1:0]   divisor,
    output logic                busy,
    output logic                done,
    output logic [DATA_W-1:0]   quotient,
    output logic [BASE_W-1:0]   remainder
);

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [BASE_W-1:0] rem_reg, rem_next;
    logic [BASE_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [BASE_W:0]   shifted;
    logic [BASE_W:0]   diff;
    logic              fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DATA_W-2:0], fits};
            rem_next  = fits ? diff[BASE_W-1:0] : shifted[BASE_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/itar_digit_stack.sv
// Last-in first-out shift stack that reverses the digit order for output.
module itar_digit_stack
    import itar_pkg::*;
#(
    parameter int DEPTH = DIGIT_SLOTS
)
(
    input  logic                 clk,
    input  itar_stack_cmd_t      cmd,
    input  logic [DIGIT_W-1:0]   push_digit,
    output logic [DIGIT_W-1:0]   top_digit
);

    logic [DIGIT_W-1:0] entry_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            entry_reg[0] <= push_digit;
            for (int i = 1; i < DEPTH; i++)
            begin
                entry_reg[i] <= entry_reg[i-1];
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                entry_reg[i] <= entry_reg[i+1];
            end
        end
    end

    assign top_digit = entry_reg[0];

endmodule
